// ===== hdl/swmm_pkg.sv =====
// Shared constants and register codes for the sliding window min/max/mean block.
package swmm_pkg;

	localparam int MAX_WINDOW_DEF  = 256;
	localparam int SAMPLE_BITS_DEF = 16;

	localparam int WSIZE_BITS = 9;
	localparam int INDEX_BITS = 16;
	localparam int ADDR_BITS  = 3;
	localparam int DATA_BITS  = 32;

	localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = WSIZE_BITS'(4);
	localparam logic [INDEX_BITS-1:0] FIRST_RESET = '0;

	typedef enum logic {
		REG_WINDOW_SIZE = 1'b0,
		REG_FIRST_INDEX = 1'b1
	} reg_idx_t;

endpackage

// ===== hdl/sliding_window_min_max_mean.sv =====
// Sliding window min/max/mean: a sample enters a row of cells; a full window yields one result.
// A sample that completes no window leaves the block ready for the next sample. A sample
// with a result runs one full rotation of the cell row, a load step, the bit-serial
// divider plus its done step, and an output step. Input stalls for all of it, and
// longer while out_stall holds a previous result. The result is registered at the end.
// Reset empties the window, clears the index and loads the register reset values.
module sliding_window_min_max_mean #(
	parameter int MAX_WINDOW  = swmm_pkg::MAX_WINDOW_DEF,
	parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [swmm_pkg::ADDR_BITS-1:0]        paddr,
	input  logic [swmm_pkg::DATA_BITS-1:0]        pwdata,
	output logic [swmm_pkg::DATA_BITS-1:0]        prdata,
	output logic                                  pready,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic signed [SAMPLE_BITS-1:0]         sample,
	input  logic                                  restart,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [swmm_pkg::INDEX_BITS-1:0]       window_start,
	output logic signed [SAMPLE_BITS-1:0]         mean,
	output logic signed [SAMPLE_BITS-1:0]         minimum,
	output logic signed [SAMPLE_BITS-1:0]         maximum
);
	import swmm_pkg::*;

	localparam int WW       = $clog2(MAX_WINDOW + 1);
	localparam int KW       = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_BITS = SAMPLE_BITS + WW;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SWEEP,
		S_LOAD,
		S_DIV,
		S_HOLD
	} state_t;

	state_t                    state_q;
	logic [WSIZE_BITS-1:0]     wsize_q;
	logic [INDEX_BITS-1:0]     first_q;
	logic [WW-1:0]             fill_q;
	logic [INDEX_BITS-1:0]     index_q;
	logic [INDEX_BITS-1:0]     start_q;
	logic [KW-1:0]             k_q;
	logic                      ovalid_q;
	logic [INDEX_BITS-1:0]     ostart_q;
	logic signed [SAMPLE_BITS-1:0] omean_q;
	logic signed [SAMPLE_BITS-1:0] omin_q;
	logic signed [SAMPLE_BITS-1:0] omax_q;

	logic                      in_fire;
	logic                      cfg_wr;
	logic [WW-1:0]             eff_w;
	logic [INDEX_BITS-1:0]     this_idx;
	logic [WW-1:0]             fill_nxt;
	logic                      rot_en;
	logic                      acc_en;
	logic signed [SAMPLE_BITS-1:0] cell_q [MAX_WINDOW];
	logic signed [SUM_BITS-1:0]    acc_sum;
	logic signed [SAMPLE_BITS-1:0] acc_lo;
	logic signed [SAMPLE_BITS-1:0] acc_hi;
	logic                      div_busy;
	logic signed [SAMPLE_BITS-1:0] div_q;

	assign pready   = 1'b1;
	assign in_stall = (state_q != S_IDLE);
	assign in_fire  = in_valid && !in_stall;
	assign cfg_wr   = psel && penable && pwrite;
	assign rot_en   = (state_q == S_SWEEP);

	// clamp the window size to 1..MAX_WINDOW
	always_comb begin
		if (wsize_q == '0) begin
			eff_w = WW'(1);
		end else if (32'(wsize_q) > MAX_WINDOW) begin
			eff_w = WW'(MAX_WINDOW);
		end else begin
			eff_w = WW'(wsize_q);
		end
	end

	assign this_idx = restart ? first_q : index_q;
	always_comb begin
		if (restart) begin
			fill_nxt = WW'(1);
		end else if (fill_q == WW'(MAX_WINDOW)) begin
			fill_nxt = fill_q;
		end else begin
			fill_nxt = fill_q + 1'b1;
		end
	end

	// register file
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsize_q <= WSIZE_RESET;
			first_q <= FIRST_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[2]))
				REG_WINDOW_SIZE: wsize_q <= pwdata[WSIZE_BITS-1:0];
				REG_FIRST_INDEX: first_q <= pwdata[INDEX_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[2]))
			REG_WINDOW_SIZE: prdata = DATA_BITS'(wsize_q);
			REG_FIRST_INDEX: prdata = DATA_BITS'(first_q);
			default:         prdata = '0;
		endcase
	end

	// row of cells: head takes the new sample, head wraps to the tail on rotate
	for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] prev_v;
		if (i == 0) begin : g_head
			assign prev_v = sample;
		end else begin : g_body
			assign prev_v = cell_q[i-1];
		end
		swmm_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
			.clk       (clk),
			.shift_en  (in_fire),
			.rot_en    (rot_en),
			.from_prev (prev_v),
			.from_next (cell_q[(i + 1) % MAX_WINDOW]),
			.q         (cell_q[i])
		);
	end

	assign acc_en = rot_en && (WW'(k_q) < eff_w);

	swmm_acc #(.SAMPLE_BITS(SAMPLE_BITS), .SUM_BITS(SUM_BITS)) u_acc (
		.clk   (clk),
		.first (rot_en && (k_q == '0)),
		.en    (acc_en),
		.v     (cell_q[0]),
		.sum   (acc_sum),
		.lo    (acc_lo),
		.hi    (acc_hi)
	);

	swmm_div #(.SUM_BITS(SUM_BITS), .DIV_BITS(WW), .Q_BITS(SAMPLE_BITS)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (state_q == S_LOAD),
		.dividend (acc_sum),
		.divisor  (eff_w),
		.busy     (div_busy),
		.quotient (div_q)
	);

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			fill_q   <= '0;
			index_q  <= '0;
			start_q  <= '0;
			k_q      <= '0;
			ovalid_q <= 1'b0;
			ostart_q <= '0;
			omean_q  <= '0;
			omin_q   <= '0;
			omax_q   <= '0;
		end else begin
			// drop the result once taken, unless a new one loads in this cycle
			if (ovalid_q && !out_stall && (state_q != S_HOLD)) begin
				ovalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						fill_q  <= fill_nxt;
						index_q <= this_idx + 1'b1;
						start_q <= this_idx - INDEX_BITS'(eff_w - 1'b1);
						k_q     <= '0;
						if (fill_nxt >= eff_w) begin
							state_q <= S_SWEEP;
						end
					end
				end
				S_SWEEP: begin
					k_q <= k_q + 1'b1;
					if (k_q == KW'(MAX_WINDOW - 1)) begin
						state_q <= S_LOAD;
					end
				end
				S_LOAD: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (!div_busy) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (!ovalid_q || !out_stall) begin
						ovalid_q <= 1'b1;
						ostart_q <= start_q;
						omean_q  <= div_q;
						omin_q   <= acc_lo;
						omax_q   <= acc_hi;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid    = ovalid_q;
	assign window_start = ostart_q;
	assign mean         = omean_q;
	assign minimum      = omin_q;
	assign maximum      = omax_q;
endmodule

// ===== hdl/swmm_cell.sv =====
// One window cell: holds a sample, takes from the previous cell on shift, the next on rotate.
module swmm_cell #(
	parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          shift_en,
	input  logic                          rot_en,
	input  logic signed [SAMPLE_BITS-1:0] from_prev,
	input  logic signed [SAMPLE_BITS-1:0] from_next,
	output logic signed [SAMPLE_BITS-1:0] q
);
	logic signed [SAMPLE_BITS-1:0] val_q;

	// shift toward older on a new sample, rotate toward the head during a sweep
	always_ff @(posedge clk) begin
		if (shift_en) begin
			val_q <= from_prev;
		end else if (rot_en) begin
			val_q <= from_next;
		end
	end

	assign q = val_q;
endmodule

// ===== hdl/swmm_acc.sv =====
// Sum, minimum and maximum accumulator fed by the head cell during a sweep.
module swmm_acc #(
	parameter int SAMPLE_BITS = swmm_pkg::SAMPLE_BITS_DEF,
	parameter int SUM_BITS    = 25
) (
	input  logic                          clk,
	input  logic                          first,
	input  logic                          en,
	input  logic signed [SAMPLE_BITS-1:0] v,
	output logic signed [SUM_BITS-1:0]    sum,
	output logic signed [SAMPLE_BITS-1:0] lo,
	output logic signed [SAMPLE_BITS-1:0] hi
);
	logic signed [SUM_BITS-1:0]    sum_q;
	logic signed [SAMPLE_BITS-1:0] lo_q;
	logic signed [SAMPLE_BITS-1:0] hi_q;

	// load on the newest sample, then fold in each older one
	always_ff @(posedge clk) begin
		if (first) begin
			sum_q <= SUM_BITS'(v);
			lo_q  <= v;
			hi_q  <= v;
		end else if (en) begin
			sum_q <= sum_q + SUM_BITS'(v);
			if (v < lo_q) begin
				lo_q <= v;
			end
			if (v > hi_q) begin
				hi_q <= v;
			end
		end
	end

	assign sum = sum_q;
	assign lo  = lo_q;
	assign hi  = hi_q;
endmodule

// ===== hdl/swmm_div.sv =====
// Restoring divider, one quotient bit per cycle: signed sum over unsigned window size.
module swmm_div #(
	parameter int SUM_BITS = 25,
	parameter int DIV_BITS = 9,
	parameter int Q_BITS   = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [SUM_BITS-1:0] dividend,
	input  logic [DIV_BITS-1:0]        divisor,
	output logic                       busy,
	output logic signed [Q_BITS-1:0]   quotient
);
	localparam int CW = $clog2(SUM_BITS + 1);

	logic                busy_q;
	logic [CW-1:0]       cnt_q;
	logic                neg_q;
	logic [DIV_BITS-1:0] d_q;
	logic [DIV_BITS-1:0] rem_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [DIV_BITS:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign fits  = (trial >= {1'b0, d_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(SUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// take the magnitude on start, then one restoring step per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= dividend[SUM_BITS-1];
			d_q   <= divisor;
			rem_q <= '0;
			quo_q <= dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
		end else if (busy_q) begin
			rem_q <= fits ? DIV_BITS'(trial - {1'b0, d_q}) : DIV_BITS'(trial);
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = neg_q ? Q_BITS'(-quo_q) : Q_BITS'(quo_q);
endmodule

// ===== verif/testbench.sv =====
// Self-checking testbench for the sliding window min/max/mean block.
`timescale 1ns / 1ps

module testbench;
	import swmm_pkg::*;

	localparam int WIN_CAP      = 256;
	localparam int SETTLE_TICKS = 400;
	localparam int STALL_LIMIT  = 20000;

	typedef struct {
		logic signed [15:0] smp;
		logic               rst;
	} sample_txn_t;

	typedef struct {
		logic [15:0]        start;
		logic signed [15:0] avg;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
	} window_stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_BITS-1:0] paddr = '0;
	logic [DATA_BITS-1:0] pwdata = '0;
	logic [DATA_BITS-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] sample;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic [15:0] window_start;
	logic signed [15:0] mean;
	logic signed [15:0] minimum;
	logic signed [15:0] maximum;

	sample_txn_t   pending_samples[$];
	window_stats_t expected_stats[$];
	int unsigned   send_idle_pct = 0;
	int unsigned   recv_idle_pct = 0;
	int            error_count = 0;
	int            quiet_cycles = 0;

	// Shadow state of the window
	logic [8:0]         shadow_wsize = WSIZE_RESET;
	logic [15:0]        shadow_first = FIRST_RESET;
	logic signed [15:0] shadow_store[WIN_CAP];
	int                 shadow_fill = 0;
	int                 shadow_wptr = 0;
	logic [15:0]        shadow_index = '0;

	sliding_window_min_max_mean uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample), .restart(restart),
		.out_valid(out_valid), .out_stall(out_stall), .window_start(window_start),
		.mean(mean), .minimum(minimum), .maximum(maximum)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Advance the shadow window by one sample and queue any window result
	function automatic void predict_window(sample_txn_t t);
		int w, pos, k, sum;
		logic [15:0] this_idx;
		logic signed [15:0] v, lo, hi;
		window_stats_t r;
		if (t.rst) begin
			shadow_fill = 0;
			shadow_wptr = 0;
			shadow_index = shadow_first;
		end
		this_idx = shadow_index;
		pos = shadow_wptr;
		shadow_store[pos] = t.smp;
		shadow_wptr = (pos + 1) % WIN_CAP;
		if (shadow_fill < WIN_CAP)
			shadow_fill++;
		shadow_index = shadow_index + 16'd1;
		w = (shadow_wsize == 0) ? 1 : (shadow_wsize > WIN_CAP) ? WIN_CAP : int'(shadow_wsize);
		if (shadow_fill < w)
			return;
		sum = 0;
		lo = t.smp;
		hi = t.smp;
		for (k = 0; k < w; k++) begin
			v = shadow_store[(pos + WIN_CAP - k) % WIN_CAP];
			sum += v;
			if (v < lo) lo = v;
			if (v > hi) hi = v;
		end
		r.start = this_idx - 16'(w - 1);
		r.avg = 16'(sum / w);
		r.lo = lo;
		r.hi = hi;
		expected_stats.push_back(r);
	endfunction

	// Sample driver: hold a stalled transaction, else send or idle
	always @(posedge clk or negedge arst_n) begin
		sample_txn_t t;
		if (!arst_n) begin
			in_valid <= 1'b0;
			sample <= '0;
			restart <= 1'b0;
		end else begin
			if (!(in_valid && in_stall)) begin
				if (in_valid)
					predict_window('{smp: sample, rst: restart});
				if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					t = pending_samples.pop_front();
					in_valid <= 1'b1;
					sample <= t.smp;
					restart <= t.rst;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Result monitor: compare each accepted transaction with the oldest prediction
	always @(posedge clk or negedge arst_n) begin
		window_stats_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_stats.size() == 0) begin
					$error("unexpected result: window_start %0d", window_start);
					error_count++;
				end else begin
					e = expected_stats.pop_front();
					if (window_start !== e.start) begin
						$error("window_start: expected %0d, got %0d", e.start, window_start);
						error_count++;
					end
					if (mean !== e.avg) begin
						$error("mean: expected %0d, got %0d", e.avg, mean);
						error_count++;
					end
					if (minimum !== e.lo) begin
						$error("minimum: expected %0d, got %0d", e.lo, minimum);
						error_count++;
					end
					if (maximum !== e.hi) begin
						$error("maximum: expected %0d, got %0d", e.hi, maximum);
						error_count++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			quiet_cycles <= 0;
		else if (quiet_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else
			quiet_cycles <= quiet_cycles + 1;
	end

	task automatic write_reg(reg_idx_t r, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_BITS'({r, 2'b00});
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (r == REG_WINDOW_SIZE)
			shadow_wsize = value[8:0];
		else
			shadow_first = value[15:0];
	endtask

	// Drain queued samples and results, then let the pipeline settle
	task automatic drain;
		@(negedge clk);
		while (pending_samples.size() > 0 || in_valid || expected_stats.size() > 0)
			@(negedge clk);
		repeat (SETTLE_TICKS) @(negedge clk);
	endtask

	task automatic push_sample(logic signed [15:0] s, logic r);
		pending_samples.push_back('{smp: s, rst: r});
	endtask

	function automatic logic signed [15:0] rand_sample();
		case ($urandom_range(9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_phase(logic [31:0] wsize, logic [31:0] first, int n, int rst_pct);
		int i;
		write_reg(REG_WINDOW_SIZE, wsize);
		write_reg(REG_FIRST_INDEX, first);
		push_sample(rand_sample(), 1'b1);
		for (i = 1; i < n; i++)
			push_sample(rand_sample(), $urandom_range(99) < rst_pct);
		drain();
	endtask

	initial begin
		int i;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Receiver idles more, then sender, then neither
		send_idle_pct = 33;
		recv_idle_pct = 53;

		// Directed: reset defaults, extremes of the sample, restart mid-window
		for (i = 0; i < 4; i++) push_sample(16'sh8000, 1'b0);
		for (i = 0; i < 4; i++) push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh0000, 1'b0);
		push_sample(-16'sd1, 1'b0);
		push_sample(16'sd1, 1'b1);
		push_sample(16'sh7fff, 1'b0);
		push_sample(16'sh8000, 1'b0);
		push_sample(-16'sd3, 1'b0);
		push_sample(16'sh5555, 1'b0);
		push_sample(16'shaaaa, 1'b0);
		push_sample(16'sh8000, 1'b1);
		push_sample(16'sh8001, 1'b0);
		drain();

		// Random phases
		run_phase(1, 16'hffff, 40, 5);
		run_phase(0, 16'hfffe, 40, 5);
		run_phase(3, $urandom_range(65535), 50, 10);
		run_phase(256, 100, 270, 0);
		send_idle_pct = 53;
		recv_idle_pct = 33;
		run_phase(511, 0, 20, 0);
		run_phase(5, 16'hfffd, 60, 8);
		run_phase(2, $urandom_range(65535), 50, 10);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		run_phase(300, 16'hffff, 270, 0);
		run_phase($urandom_range(16, 1), 0, 60, 6);
		run_phase(7, $urandom_range(65535), 50, 6);

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
